// ===== design/ppmfd_pkg.sv =====
// shared constants, codes and types of the ppm frame decoder
package ppmfd_pkg;

  // channel slots per frame and the fixed set of latched outputs
  localparam int CHANNELS = 8;
  localparam int LATCH_N  = 8;

  localparam int IDX_W  = $clog2(CHANNELS);
  localparam int SLOT_W = $clog2(CHANNELS + 1);

  localparam int PIN_W  = 16;
  localparam int TIME_W = 32;
  localparam int VAL_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] BOUND_PIN_RST     = 16'd256;
  localparam logic [VAL_W-1:0] FRAME_GAP_MIN_RST = 16'd3000;
  localparam logic [VAL_W-1:0] PULSE_MIN_RST     = 16'd800;
  localparam logic [VAL_W-1:0] PULSE_MAX_RST     = 16'd2200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUND_PIN     = 2'd0,
    REG_FRAME_GAP_MIN = 2'd1,
    REG_PULSE_MIN     = 2'd2,
    REG_PULSE_MAX     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_RESYNC   = 3'd1,
    ST_STORED   = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_BAD      = 3'd4,
    ST_ACQUIRED = 3'd5,
    ST_WAITING  = 3'd6
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] bound_pin;
    logic [VAL_W-1:0] frame_gap_min;
    logic [VAL_W-1:0] pulse_min;
    logic [VAL_W-1:0] pulse_max;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] prev_time;
    logic              synced;
    logic [SLOT_W-1:0] slot_count;
    logic              update_mark;
  } dec_state_t;

  typedef struct packed {
    status_t           status;
    logic [2:0]        chan;
    logic [VAL_W-1:0]  width;
    dec_state_t        st_next;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [VAL_W-1:0]  wr_data;
    logic              latch_en;
  } decision_t;

endpackage

// ===== design/ppmfd_edge_if.sv =====
// edge event channel: pin mask and microsecond timestamp
interface ppmfd_edge_if;
  import ppmfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIN_W-1:0]  edge_pin;
  logic [TIME_W-1:0] timestamp_us;

  modport source (output valid, edge_pin, timestamp_us, input ready);
  modport sink   (input valid, edge_pin, timestamp_us, output ready);
endinterface

// ===== design/ppmfd_result_if.sv =====
// decoder result channel: status, slot and latched frame values
interface ppmfd_result_if;
  import ppmfd_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic             update_flag;
  logic [2:0]       channel_index;
  logic [VAL_W-1:0] pulse_width;
  logic [VAL_W-1:0] left_x;
  logic [VAL_W-1:0] left_y;
  logic [VAL_W-1:0] right_x;
  logic [VAL_W-1:0] right_y;
  logic [VAL_W-1:0] switch_a;
  logic [VAL_W-1:0] switch_b;
  logic [VAL_W-1:0] switch_c;
  logic [VAL_W-1:0] switch_d;

  modport source (output valid, status, update_flag, channel_index, pulse_width,
                  left_x, left_y, right_x, right_y,
                  switch_a, switch_b, switch_c, switch_d,
                  input ready);
  modport sink   (input valid, status, update_flag, channel_index, pulse_width,
                  left_x, left_y, right_x, right_y,
                  switch_a, switch_b, switch_c, switch_d,
                  output ready);
endinterface

// ===== design/ppmfd_classify.sv =====
// edge classification: interval, window tests and next decoder state
module ppmfd_classify (
  input  logic [ppmfd_pkg::PIN_W-1:0]  pin,
  input  logic [ppmfd_pkg::TIME_W-1:0] now,
  input  ppmfd_pkg::cfg_t              cfg,
  input  ppmfd_pkg::dec_state_t        st,
  output ppmfd_pkg::decision_t         dec
);
  import ppmfd_pkg::*;

  logic [TIME_W-1:0] delta;
  logic              pin_match;
  logic              is_gap;
  logic              in_window;
  logic [IDX_W-1:0]  slot;
  logic              last_slot;

  assign pin_match = (pin == cfg.bound_pin);
  assign delta     = now - st.prev_time;
  assign is_gap    = (delta >= {{(TIME_W-VAL_W){1'b0}}, cfg.frame_gap_min});
  assign in_window = (delta >= {{(TIME_W-VAL_W){1'b0}}, cfg.pulse_min}) &&
                     (delta <= {{(TIME_W-VAL_W){1'b0}}, cfg.pulse_max});

  // slot count never passes the last slot, clamp kept for safety
  assign slot = (st.slot_count >= SLOT_W'(CHANNELS)) ? IDX_W'(CHANNELS - 1)
                                                     : st.slot_count[IDX_W-1:0];
  assign last_slot = (slot == IDX_W'(CHANNELS - 1));

  always_comb begin
    dec          = '0;
    dec.status   = ST_IGNORED;
    dec.st_next  = st;
    dec.wr_idx   = slot;
    dec.wr_data  = delta[VAL_W-1:0];
    if (pin_match) begin
      dec.st_next.prev_time = now;
      dec.width = (|delta[TIME_W-1:VAL_W]) ? {VAL_W{1'b1}} : delta[VAL_W-1:0];
      if (st.synced) begin
        if (is_gap) begin
          dec.st_next.slot_count  = '0;
          dec.st_next.update_mark = 1'b1;
          dec.status              = ST_RESYNC;
        end else if (in_window) begin
          dec.wr_en = 1'b1;
          dec.chan  = 3'(slot);
          if (last_slot) begin
            dec.latch_en           = 1'b1;
            dec.st_next.synced     = 1'b0;
            dec.st_next.slot_count = '0;
            dec.status             = ST_COMPLETE;
          end else begin
            dec.st_next.slot_count = SLOT_W'(slot) + 1'b1;
            dec.status             = ST_STORED;
          end
        end else begin
          dec.st_next.synced     = 1'b0;
          dec.st_next.slot_count = '0;
          dec.status             = ST_BAD;
        end
      end else if (is_gap) begin
        dec.st_next.synced      = 1'b1;
        dec.st_next.slot_count  = '0;
        dec.st_next.update_mark = 1'b0;
        dec.status              = ST_ACQUIRED;
      end else begin
        dec.status = ST_WAITING;
      end
    end
  end

endmodule

// ===== design/ppm_frame_decoder_top.sv =====
// ppm frame decoder top level: input register, classification, result register
//
//  channel     | dir | handshake         | payload
//  ------------+-----+-------------------+-----------------------------------------
//  edge_in     | in  | valid / ready     | edge_pin, timestamp_us
//  result_out  | out | valid / ready     | status, update_flag, channel_index,
//              |     |                   | pulse_width, sticks, switches
//  cfg         | in  | cfg_we            | cfg_index, cfg_data
//
// one item per clock while result_out is not stalled; an accepted item is shown once it
// has passed the input register and then the result register
// decoder state and the latched frame advance on the edge an item moves into the
// result register, so the frame values on the port always belong to the shown item
// reset (rst, synchronous) empties both registers and loads the register defaults
// a stalled result still lets one more item into the input register
module ppm_frame_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppmfd_pkg::VAL_W-1:0]    cfg_data,
  ppmfd_edge_if.sink                     edge_in,
  ppmfd_result_if.source                 result_out
);
  import ppmfd_pkg::*;

  // configuration registers
  cfg_t cfg;

  // input register
  logic              s1_valid;
  logic [PIN_W-1:0]  s1_pin;
  logic [TIME_W-1:0] s1_time;

  // result register
  logic             out_valid;
  status_t          out_status;
  logic [2:0]       out_chan;
  logic [VAL_W-1:0] out_width;

  // decoder state
  dec_state_t       st;
  logic [VAL_W-1:0] slot_buf  [CHANNELS];
  logic [VAL_W-1:0] slot_view [CHANNELS];
  logic [VAL_W-1:0] latched   [LATCH_N];
  logic [VAL_W-1:0] latch_next[LATCH_N];

  decision_t dec;
  logic      out_free;
  logic      s1_adv;

  assign out_free      = !out_valid || result_out.ready;
  assign s1_adv        = s1_valid && out_free;
  assign edge_in.ready = !s1_valid || out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bound_pin     <= BOUND_PIN_RST;
      cfg.frame_gap_min <= FRAME_GAP_MIN_RST;
      cfg.pulse_min     <= PULSE_MIN_RST;
      cfg.pulse_max     <= PULSE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOUND_PIN:     cfg.bound_pin     <= cfg_data;
        REG_FRAME_GAP_MIN: cfg.frame_gap_min <= cfg_data;
        REG_PULSE_MIN:     cfg.pulse_min     <= cfg_data;
        REG_PULSE_MAX:     cfg.pulse_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (edge_in.ready) begin
      s1_valid <= edge_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_in.valid && edge_in.ready) begin
      s1_pin  <= edge_in.edge_pin;
      s1_time <= edge_in.timestamp_us;
    end
  end

  ppmfd_classify u_classify (
    .pin (s1_pin),
    .now (s1_time),
    .cfg (cfg),
    .st  (st),
    .dec (dec)
  );

  // slot contents as they stand once this item's pulse is written,
  // so the completing pulse reaches the latch in the same cycle
  for (genvar g = 0; g < CHANNELS; g++) begin : g_slot
    assign slot_view[g] = (dec.wr_en && dec.wr_idx == IDX_W'(g)) ? dec.wr_data
                                                                 : slot_buf[g];

    always_ff @(posedge clk) begin
      if (s1_adv && dec.wr_en && dec.wr_idx == IDX_W'(g)) begin
        slot_buf[g] <= dec.wr_data;
      end
    end
  end

  // latched outputs beyond the channel count read as zero
  for (genvar g = 0; g < LATCH_N; g++) begin : g_latch
    if (g < CHANNELS) begin : g_used
      assign latch_next[g] = slot_view[g];
    end else begin : g_unused
      assign latch_next[g] = '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        latched[g] <= '0;
      end else if (s1_adv && dec.latch_en) begin
        latched[g] <= latch_next[g];
      end
    end
  end

  // decoder state and result register move together
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        st <= dec.st_next;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status <= dec.status;
      out_chan   <= dec.chan;
      out_width  <= dec.width;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.status        = out_status;
  assign result_out.update_flag   = st.update_mark;
  assign result_out.channel_index = out_chan;
  assign result_out.pulse_width   = out_width;

  // stick order swaps channels two and three
  assign result_out.left_x   = latched[0];
  assign result_out.left_y   = latched[1];
  assign result_out.right_x  = latched[3];
  assign result_out.right_y  = latched[2];
  assign result_out.switch_a = latched[4];
  assign result_out.switch_b = latched[5];
  assign result_out.switch_c = latched[6];
  assign result_out.switch_d = latched[7];

endmodule

// ===== design/ppmfd_checker.sv =====
// port-level checks of the ppm frame decoder and their bind
module ppmfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        update_flag,
  input logic [2:0]  channel_index,
  input logic [15:0] pulse_width,
  input logic [15:0] left_x
);
  import ppmfd_pkg::*;

  // a stalled result holds its item
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pulse_width))
    else $error("result changed while stalled");

  // ignored edges report no slot and no interval
  a_ignored_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_IGNORED |-> channel_index == 3'd0 && pulse_width == '0)
    else $error("ignored edge carries slot or width");

  // a slot index only when a pulse was stored
  a_chan_only_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_STORED && status != ST_COMPLETE |-> channel_index == 3'd0)
    else $error("slot index without stored pulse");

  // resync sets the update flag, acquiring sync clears it
  a_update_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RESYNC || status == ST_ACQUIRED)
      |-> update_flag == (status == ST_RESYNC))
    else $error("update flag disagrees with status");

  // the latched frame moves only with a completed frame
  a_latch_on_complete: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(left_x) |-> out_valid && status == ST_COMPLETE)
    else $error("latched frame changed without frame completion");

endmodule

bind ppm_frame_decoder_top ppmfd_checker u_ppmfd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .status        (result_out.status),
  .update_flag   (result_out.update_flag),
  .channel_index (result_out.channel_index),
  .pulse_width   (result_out.pulse_width),
  .left_x        (result_out.left_x)
);
